[design/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner package
// Shared constants, types and register codes for the scanner blocks.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int LEN_W        = $clog2(MAX_PATTERN + 1);
  localparam int OFFSET_BITS  = 32;
  localparam int START_W      = 32;
  localparam int MATCH_W      = 8;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_WANTED   = 2'd3
  } reg_idx_t;

  typedef logic [MAX_PATTERN-1:0] hits_t;

  // Classified byte: which pattern positions accept it, plus the end flag
  typedef struct packed {
    hits_t mask;
    logic  last;
  } scan_item_t;

  typedef struct packed {
    logic [MAX_PATTERN-1:0][7:0] pat;
    logic [LEN_W-1:0]            len;
    logic [MATCH_W-1:0]          wanted;
  } scan_cfg_t;

  typedef struct packed {
    logic       valid;
    scan_item_t item;
  } queue_push_t;

endpackage

[design/wbps_ifs.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner channels
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] start_offset;

  modport source (output valid, output found, output start_offset, input ready);
  modport sink   (input valid, input found, input start_offset, output ready);
endinterface

interface wbps_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/wildcard_byte_pattern_scanner_unit.sv]
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner
// A result word is registered in the back end after its byte's classified word leaves the queue.
// Throughput: one byte per cycle while the queue has room; the shift-and update sets the rate.
// A two-entry queue keeps bytes flowing while a result waits on the output.
// Reset (synchronous, active low) clears registers, match state and the queue.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wbps_in_if.sink    in_bus,
  wbps_out_if.source out_bus,
  wbps_cfg_if.sink   cfg_bus
);

  scan_cfg_t   cfg;
  queue_push_t push;
  logic        queue_ready;
  logic        item_valid;
  scan_item_t  item;
  logic        pop;

  wbps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  wbps_front u_front (
    .in_bus      (in_bus),
    .cfg         (cfg),
    .queue_ready (queue_ready),
    .push        (push)
  );

  wbps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (queue_ready),
    .pop_valid  (item_valid),
    .pop_item   (item),
    .pop        (pop)
  );

  wbps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule

[design/wbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Scanner configuration registers
// Holds the pattern, its length (clamped) and the wanted match number.
// ----------------------------------------------------------------------------
module wbps_cfg_regs
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wbps_cfg_if.sink   cfg_bus,
  output scan_cfg_t  cfg
);

  logic [CFG_DATA_W-1:0] pat_low_r, pat_low_nxt;
  logic [CFG_DATA_W-1:0] pat_high_r, pat_high_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [MATCH_W-1:0]    wanted_r, wanted_nxt;
  logic [4:0]            len_wr;
  logic                  wr_en;

  assign cfg_bus.ready = 1'b1;
  assign wr_en         = cfg_bus.valid && cfg_bus.ready;
  assign len_wr        = cfg_bus.data[4:0];

  always_comb begin
    pat_low_nxt  = pat_low_r;
    pat_high_nxt = pat_high_r;
    len_nxt      = len_r;
    wanted_nxt   = wanted_r;
    if (wr_en) begin
      unique case (cfg_bus.index)
        REG_PAT_LOW:  pat_low_nxt  = cfg_bus.data;
        REG_PAT_HIGH: pat_high_nxt = cfg_bus.data;
        // store the length already clamped to the pattern size
        REG_PAT_LEN:  len_nxt = (len_wr > 5'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : LEN_W'(len_wr);
        REG_WANTED:   wanted_nxt   = cfg_bus.data[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_r      <= '0;
      wanted_r   <= '0;
    end else begin
      pat_low_r  <= pat_low_nxt;
      pat_high_r <= pat_high_nxt;
      len_r      <= len_nxt;
      wanted_r   <= wanted_nxt;
    end
  end

  assign cfg.pat    = {pat_high_r, pat_low_r};
  assign cfg.len    = len_r;
  assign cfg.wanted = wanted_r;

endmodule

[design/wbps_front.sv]
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts bytes and classifies each against every pattern position.
// ----------------------------------------------------------------------------
module wbps_front
  import wbps_pkg::*;
(
  wbps_in_if.sink     in_bus,
  input  scan_cfg_t   cfg,
  input  logic        queue_ready,
  output queue_push_t push
);

  hits_t mask;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      mask[i] = ((cfg.pat[i] == WILDCARD_BYTE) || (cfg.pat[i] == in_bus.data_byte))
                && (LEN_W'(i) < cfg.len);
    end
  end

  assign in_bus.ready   = queue_ready;
  assign push.valid     = in_bus.valid && queue_ready;
  assign push.item.mask = mask;
  assign push.item.last = in_bus.region_end;

endmodule

[design/wbps_queue.sv]
// ----------------------------------------------------------------------------
// Scanner item queue
// Short FIFO of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module wbps_queue
  import wbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  queue_push_t push,
  output logic        push_ready,
  output logic        pop_valid,
  output scan_item_t  pop_item,
  input  logic        pop
);

  scan_item_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.item;
    end
  end

endmodule

[design/wbps_back.sv]
// ----------------------------------------------------------------------------
// Scanner back end
// Runs the shift-and match, counts matches and registers the result word.
// ----------------------------------------------------------------------------
module wbps_back
  import wbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  scan_cfg_t  cfg,
  input  logic       item_valid,
  input  scan_item_t item,
  output logic       pop,
  wbps_out_if.source out_bus
);

  hits_t                  hits_r, hits_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [MATCH_W-1:0]     seen_r, seen_nxt;
  logic                   reported_r, reported_nxt;
  logic                   out_valid_r;
  logic                   found_r, found_nxt;
  logic [START_W-1:0]     start_r, start_nxt;
  hits_t                  shifted;
  logic                   hit;
  logic                   emit;
  logic                   out_free;
  logic [OFFSET_BITS-1:0] start_full;
  logic [LEN_W-1:0]       len_m1;

  assign shifted    = {hits_r[MAX_PATTERN-2:0], 1'b1} & item.mask;
  assign len_m1     = cfg.len - 1'b1;
  assign hit        = (cfg.len != '0) && shifted[len_m1[$clog2(MAX_PATTERN)-1:0]];
  assign start_full = offset_r - OFFSET_BITS'(cfg.len) + 1'b1;
  assign out_free   = !out_valid_r || out_bus.ready;

  always_comb begin
    hits_nxt     = hits_r;
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    emit         = 1'b0;
    found_nxt    = 1'b0;
    start_nxt    = '0;
    if (!reported_r) begin
      if (cfg.len != '0) begin
        hits_nxt = shifted;
        if (hit) begin
          // restart after a full match: no overlap
          hits_nxt = '0;
          if (seen_r == cfg.wanted) begin
            emit         = 1'b1;
            found_nxt    = 1'b1;
            start_nxt    = start_full[START_W-1:0];
            reported_nxt = 1'b1;
          end else if (seen_r != '1) begin
            seen_nxt = seen_r + 1'b1;
          end
        end
      end else begin
        hits_nxt = '0;
      end
      if (item.last && !reported_nxt) begin
        emit = 1'b1;
      end
    end
    offset_nxt = offset_r + 1'b1;
    if (item.last) begin
      hits_nxt     = '0;
      offset_nxt   = '0;
      seen_nxt     = '0;
      reported_nxt = 1'b0;
    end
  end

  // words without a result advance even while the output is stalled
  assign pop = item_valid && (!emit || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      offset_r    <= '0;
      seen_r      <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        hits_r     <= hits_nxt;
        offset_r   <= offset_nxt;
        seen_r     <= seen_nxt;
        reported_r <= reported_nxt;
      end
      if (pop && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      found_r <= found_nxt;
      start_r <= start_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.found        = found_r;
  assign out_bus.start_offset = start_r;

endmodule

[design/wbps_checker.sv]
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the top-level channels over time; attached by bind.
// ----------------------------------------------------------------------------
module wbps_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_start_offset,
  input logic        cfg_ready
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_start_offset))
    else $error("result word dropped or changed while stalled");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_start_offset == 32'd0)
    else $error("not-found result carries a nonzero offset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("register port stalled");

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_port_checker u_wbps_port_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_bus.ready),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_found        (out_bus.found),
  .out_start_offset (out_bus.start_offset),
  .cfg_ready        (cfg_bus.ready)
);
